// ===== hw/rtl/mavg_pkg.sv =====
// Shared constants, codes and types of the moving average filter.
package mavg_pkg;

   localparam int DATA_W     = 16;
   localparam int WINDOW_DEF = 100;
   localparam int FIFO_DEPTH = 8;

   localparam logic [DATA_W-1:0] PRESET_RESET = DATA_W'(2000);

   // Request kinds carried on tuser
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_REFILL = 1'b1;

   typedef struct packed {
      logic              accept;
      logic              kind;
      logic [DATA_W-1:0] sample;
   } req_beat_type;

endpackage

// ===== hw/rtl/mavg_ring.sv =====
// Sample ring memory with read-modify-write of the running sum.
module mavg_ring import mavg_pkg::*; #(
   parameter int  WINDOW = WINDOW_DEF,
   localparam int SUM_W  = DATA_W + $clog2(WINDOW),
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  req_beat_type      req_beat,
   input  logic [DATA_W-1:0] preset,
   output logic              sum_valid,
   output logic [SUM_W-1:0]  sum
);

   localparam logic [SUM_W-1:0]  WIN_SUM   = SUM_W'(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(PRESET_RESET) * WIN_SUM;

   logic [DATA_W-1:0] ring_mem [WINDOW];

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              full_ff, full_in;
   logic [DATA_W-1:0] fill_ff, fill_in;

   logic              s1_valid_ff;
   logic              s1_kind_ff;
   logic [DATA_W-1:0] s1_sample_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic              s1_full_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic              lw_valid_ff;
   logic [SLOT_W-1:0] lw_slot_ff;
   logic [DATA_W-1:0] lw_data_ff;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              sum_valid_ff;
   logic              wr_en;
   logic [DATA_W-1:0] old_data;

   // Ring pointer, wrap flag and fill value move at acceptance
   always_comb begin
      slot_in = slot_ff;
      full_in = full_ff;
      fill_in = fill_ff;
      if (req_beat.accept) begin
         if (req_beat.kind == REQ_REFILL) begin
            slot_in = '0;
            full_in = 1'b0;
            fill_in = preset;
         end else if (slot_ff == SLOT_LAST) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         full_ff     <= 1'b0;
         fill_ff     <= PRESET_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         full_ff     <= full_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= req_beat.accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff   <= req_beat.kind;
      s1_sample_ff <= req_beat.sample;
      s1_slot_ff   <= slot_ff;
      s1_full_ff   <= full_ff;
   end

   assign wr_en = s1_valid_ff && (s1_kind_ff == REQ_SAMPLE);

   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[slot_ff];
      if (wr_en) begin
         ring_mem[s1_slot_ff] <= s1_sample_ff;
      end
   end

   // Remember the write of the last edge: the read taken at that same edge missed it
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff <= wr_en;
      end
      lw_slot_ff <= s1_slot_ff;
      lw_data_ff <= s1_sample_ff;
   end

   // Slots not written since the last refill still hold the fill value
   always_comb begin
      if (!s1_full_ff) begin
         old_data = fill_ff;
      end else if (lw_valid_ff && (lw_slot_ff == s1_slot_ff)) begin
         old_data = lw_data_ff;
      end else begin
         old_data = rd_data_ff;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (s1_valid_ff) begin
         if (s1_kind_ff == REQ_REFILL) begin
            sum_in = SUM_W'(fill_ff) * WIN_SUM;
         end else begin
            sum_in = sum_ff - SUM_W'(old_data) + SUM_W'(s1_sample_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= SUM_RESET;
         sum_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         sum_valid_ff <= wr_en;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

// ===== hw/rtl/mavg_div.sv =====
// Division of the running sum by the window length through a reciprocal multiply.
module mavg_div import mavg_pkg::*; #(
   parameter int  WINDOW = WINDOW_DEF,
   localparam int SUM_W  = DATA_W + $clog2(WINDOW)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sum_valid,
   input  logic [SUM_W-1:0]  sum,
   output logic              avg_valid,
   output logic [DATA_W-1:0] avg
);

   // floor(x / W) == (x * ceil(2^S / W)) >> S for every SUM_W-bit x
   localparam int          SHIFT  = SUM_W + $clog2(WINDOW);
   localparam int          MUL_W  = SUM_W + 1;
   localparam int          PROD_W = SUM_W + MUL_W;
   localparam logic [63:0] RECIP  =
      ((64'd1 << SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
   localparam logic [MUL_W-1:0] MUL = MUL_W'(RECIP);

   logic [PROD_W-1:0] prod_ff;
   logic              prod_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= sum_valid;
      end
      prod_ff <= PROD_W'(sum) * PROD_W'(MUL);
   end

   assign avg_valid = prod_valid_ff;
   assign avg       = prod_ff[SHIFT +: DATA_W];

endmodule

// ===== hw/rtl/mavg_fifo.sv =====
// Result queue with credit count covering results still in the pipeline.
module mavg_fifo import mavg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              reserve,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  credit_ff, credit_in;
   logic              pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (occ_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign room      = (credit_ff < CNT_W'(FIFO_DEPTH));

   always_comb begin
      occ_in    = occ_ff + CNT_W'(push) - CNT_W'(pop);
      credit_in = credit_ff + CNT_W'(reserve) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
         credit_ff <= '0;
      end else begin
         occ_ff    <= occ_in;
         credit_ff <= credit_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/moving_average_filter_unit.sv =====
// Top level of the boxcar moving average filter.
//
//   channel   direction  tdata / data            tuser
//   req_*     in         sample [15:0]           req_type [0] (0 sample, 1 refill)
//   rsp_*     out        average [15:0]          -
//   csr_*     in         preset_value [15:0]     -
//
// One request per cycle while the result queue has room. A sample's average goes
// through the ring read, sum update and reciprocal multiply registers into the result
// queue, which then raises rsp_tvalid.
// The ring memory takes one read and one write per cycle; an eight-entry result queue
// paces req_tready, so a stalled rsp side holds back requests after eight samples.
// Reset is synchronous; the window reads as the preset value right away.
module moving_average_filter_unit import mavg_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [15:0] sample
   input  logic [0:0]        req_tuser,   // [0] req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [15:0] average
   input  logic              csr_we,
   input  logic [DATA_W-1:0] csr_wdata    // [15:0] preset_value
);

   localparam int SUM_W = DATA_W + $clog2(WINDOW);

   logic [DATA_W-1:0] preset_ff;
   req_beat_type      req_beat;
   logic              sum_valid;
   logic [SUM_W-1:0]  sum;
   logic              avg_valid;
   logic [DATA_W-1:0] avg;
   logic              room;
   logic              sample_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff <= PRESET_RESET;
      end else if (csr_we) begin
         preset_ff <= csr_wdata;
      end
   end

   assign req_tready      = room;
   assign req_beat.accept = req_tvalid && room;
   assign req_beat.kind   = req_tuser[0];
   assign req_beat.sample = req_tdata;

   // Only sample requests produce an average, so only they take a queue credit
   assign sample_accept = req_beat.accept && (req_beat.kind == REQ_SAMPLE);

   mavg_ring #(.WINDOW(WINDOW)) u_ring (
      .clock     (clock),
      .reset     (reset),
      .req_beat  (req_beat),
      .preset    (preset_ff),
      .sum_valid (sum_valid),
      .sum       (sum)
   );

   mavg_div #(.WINDOW(WINDOW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum       (sum),
      .avg_valid (avg_valid),
      .avg       (avg)
   );

   mavg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .reserve   (sample_accept),
      .push      (avg_valid),
      .push_data (avg),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/mavg_checker.sv =====
// Port-level checks of the moving average filter, bound to the top level.
module mavg_checker import mavg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [DATA_W-1:0] req_tdata,
   input logic [0:0]        req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              csr_we,
   input logic [DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 2);

   logic             sample_acc;
   logic             rsp_acc;
   logic [CNT_W-1:0] owed_ff;

   assign sample_acc = req_tvalid && req_tready && (req_tuser[0] == REQ_SAMPLE);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // Count sample requests whose average is not delivered yet
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_ff + CNT_W'(sample_acc) - CNT_W'(rsp_acc);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> owed_ff != '0)
      else $error("response without a pending sample request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= CNT_W'(FIFO_DEPTH))
      else $error("more requests pending than queue entries");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      sample_acc && owed_ff == '0 |-> ##4 rsp_tvalid)
      else $error("average late on an empty pipeline");

endmodule

bind moving_average_filter_unit mavg_checker u_mavg_checker (.*);
